@@ rtl/dsst_pkg.sv @@
// Shared widths, register codes, operand record and helpers of the diffusion stencil block.
package dsst_pkg;

  localparam int MAX_GRID = 4096;
  localparam int ADDR_W   = $clog2(MAX_GRID);
  localparam int SIDE_W   = $clog2(MAX_GRID + 1);

  localparam int CELL_W   = 32;
  localparam int GRID_W   = 13;
  localparam int GAIN_W   = 15;
  localparam int FRAC_W   = 16;

  localparam int CFG_DATA_W = 15;
  localparam int CFG_IDX_W  = 1;

  // Laplacian holds four cells minus four times a cell, signed.
  localparam int LAP_W   = CELL_W + 4;
  localparam int PROD_W  = LAP_W + GAIN_W + 1;
  localparam int DELTA_W = PROD_W - FRAC_W;
  localparam int SUM_W   = DELTA_W + 2;

  localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_W - 1);

  localparam logic [GRID_W-1:0] GRID_RESET = GRID_W'(4096);
  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(66);

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_SIZE      = 1'b0,
    REG_DIFFUSION_GAIN = 1'b1
  } dsst_reg_t;

  typedef enum logic {
    KIND_CELL  = 1'b0,
    KIND_FLUSH = 1'b1
  } dsst_kind_t;

  // Everything the arithmetic needs for one result.
  typedef struct packed {
    logic [CELL_W-1:0] up;
    logic [CELL_W-1:0] below;
    logic [CELL_W-1:0] left;
    logic [CELL_W-1:0] old;
    logic [CELL_W-1:0] right;
    logic              border;
    logic              last;
  } dsst_op_t;

  // Grid side as used: the written size clamped to the supported range.
  function automatic logic [SIDE_W-1:0] dsst_side(input logic [GRID_W-1:0] grid);
    int unsigned gv;
    int unsigned nv;
    gv = 32'(grid);
    if (gv < 32'd3) begin
      nv = 32'd3;
    end else if (gv > 32'(MAX_GRID)) begin
      nv = 32'(MAX_GRID);
    end else begin
      nv = gv;
    end
    return SIDE_W'(nv);
  endfunction

endpackage

@@ rtl/dsst_channels.sv @@
// Valid/ready stream interfaces for the cell input and the result output.
interface dsst_in_if import dsst_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [CELL_W-1:0] cell_value;

  modport source (output valid, output kind, output cell_value, input ready);
  modport sink (input valid, input kind, input cell_value, output ready);
endinterface

interface dsst_out_if import dsst_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CELL_W-1:0] new_value;
  logic              last_of_frame;

  modport source (output valid, output new_value, output last_of_frame, input ready);
  modport sink (input valid, input new_value, input last_of_frame, output ready);
endinterface

@@ rtl/dsst_ram.sv @@
// Generic single-write, single-read RAM with registered read data (read returns old data).
module dsst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/dsst_front.sv @@
// Front end: accepts items, tracks raster position, runs the row delay lines, builds operands.
module dsst_front import dsst_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  dsst_in_if.sink            in_stream,
  input  logic [SIDE_W-1:0]  side,
  input  logic               restart,
  input  logic [Q_CNT_W-1:0] q_count,
  output logic               push,
  output dsst_op_t           push_op
);

  localparam int OCC_W = Q_CNT_W + 1;
  localparam logic [1:0] ROW_SAT = 2'd2;

  logic [ADDR_W-1:0] nm1;
  logic              xfer;
  logic              done;
  logic              step;
  logic              emit;
  logic              border;
  logic              last;
  logic [CELL_W-1:0] x;
  logic [OCC_W-1:0]  occ;

  logic [ADDR_W-1:0] col_r, col_nxt;
  logic [1:0]        row_r, row_nxt;
  logic [ADDR_W-1:0] pr_r, pr_nxt;
  logic [ADDR_W-1:0] pc_r, pc_nxt;
  logic [CELL_W-1:0] below_r;

  // Stage 1: middle delay line read data is valid.
  logic              v1_r;
  logic              emit1_r;
  logic              border1_r;
  logic              last1_r;
  logic [ADDR_W-1:0] ci1_r;
  logic [CELL_W-1:0] below1_r;
  logic [CELL_W-1:0] f1_r;
  logic [CELL_W-1:0] f2_r;
  logic [CELL_W-1:0] mid_rdata;

  // Stage 2: upper delay line read data is valid.
  logic              v2_r;
  logic              emit2_r;
  logic              border2_r;
  logic              last2_r;
  logic [CELL_W-1:0] below2_r;
  logic [CELL_W-1:0] left2_r;
  logic [CELL_W-1:0] old2_r;
  logic [CELL_W-1:0] right2_r;
  logic [CELL_W-1:0] up_prev_r;
  logic [CELL_W-1:0] above_rdata;

  assign nm1 = ADDR_W'(side - SIDE_W'(1));

  // Everything in flight may still land in the queue, so count it against the room left.
  assign occ = OCC_W'(q_count) + OCC_W'(v1_r) + OCC_W'(v2_r);
  assign in_stream.ready = occ < OCC_W'(Q_DEPTH);
  assign xfer = in_stream.valid && in_stream.ready;

  // All cells of the frame are in once the pending result reaches the last cell of the second-last row.
  assign done = (pr_r == nm1) || ((pr_r == nm1 - ADDR_W'(1)) && (pc_r == nm1));
  assign step = xfer && !((in_stream.kind == KIND_FLUSH) && !done);
  assign x    = ((in_stream.kind == KIND_CELL) && !done) ? in_stream.cell_value : '0;
  assign emit = (row_r == ROW_SAT) || ((row_r == 2'd1) && (col_r != '0));

  assign border = (pr_r == '0) || (pr_r == nm1) || (pc_r == '0) || (pc_r == nm1);
  assign last   = (pr_r == nm1) && (pc_r == nm1);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    pr_nxt  = pr_r;
    pc_nxt  = pc_r;
    if (step) begin
      if (col_r == nm1) begin
        col_nxt = '0;
        if (row_r != ROW_SAT) begin
          row_nxt = row_r + 2'd1;
        end
      end else begin
        col_nxt = col_r + ADDR_W'(1);
      end
      if (emit) begin
        if (pc_r == nm1) begin
          pc_nxt = '0;
          pr_nxt = pr_r + ADDR_W'(1);
        end else begin
          pc_nxt = pc_r + ADDR_W'(1);
        end
      end
    end
    if (restart || (step && emit && last)) begin
      col_nxt = '0;
      row_nxt = '0;
      pr_nxt  = '0;
      pc_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      pr_r  <= '0;
      pc_r  <= '0;
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      pr_r  <= pr_nxt;
      pc_r  <= pc_nxt;
      v1_r  <= step;
      v2_r  <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      below_r   <= x;
      emit1_r   <= emit;
      border1_r <= border;
      last1_r   <= last;
      ci1_r     <= col_r;
      below1_r  <= below_r;
    end
    if (v1_r) begin
      emit2_r   <= emit1_r;
      border2_r <= border1_r;
      last2_r   <= last1_r;
      below2_r  <= below1_r;
      left2_r   <= f2_r;
      old2_r    <= f1_r;
      right2_r  <= mid_rdata;
      f1_r      <= mid_rdata;
      f2_r      <= f1_r;
    end
    if (v2_r) begin
      up_prev_r <= above_rdata;
    end
  end

  // Middle line: a column-addressed delay of one row on the incoming stream.
  dsst_ram #(.WIDTH(CELL_W), .DEPTH(MAX_GRID)) u_mid_ram (
    .clk   (clk),
    .we    (step),
    .waddr (col_r),
    .wdata (x),
    .raddr (col_r),
    .rdata (mid_rdata)
  );

  // Upper line: one more row of delay on what leaves the middle line.
  dsst_ram #(.WIDTH(CELL_W), .DEPTH(MAX_GRID)) u_above_ram (
    .clk   (clk),
    .we    (v1_r),
    .waddr (ci1_r),
    .wdata (mid_rdata),
    .raddr (ci1_r),
    .rdata (above_rdata)
  );

  assign push = v2_r && emit2_r;

  always_comb begin
    push_op.up     = up_prev_r;
    push_op.below  = below2_r;
    push_op.left   = left2_r;
    push_op.old    = old2_r;
    push_op.right  = right2_r;
    push_op.border = border2_r;
    push_op.last   = last2_r;
  end

  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    step && emit && last |=> (col_r == '0) && (row_r == '0) && (pr_r == '0) && (pc_r == '0))
    else $error("frame counters not cleared after the final result");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (col_r <= nm1) && (pc_r <= nm1) && (pr_r <= nm1))
    else $error("raster position beyond grid side");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (q_count < Q_CNT_W'(Q_DEPTH)))
    else $error("operand queue overrun");

endmodule

@@ rtl/dsst_fifo.sv @@
// Short operand queue between the front end and the arithmetic back end.
module dsst_fifo import dsst_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  dsst_op_t           push_op,
  input  logic               pop,
  output dsst_op_t           head_op,
  output logic [Q_CNT_W-1:0] count
);

  dsst_op_t           entries [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + Q_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + Q_PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + Q_CNT_W'(push) - Q_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr_r] <= push_op;
    end
  end

  assign head_op = entries[rd_ptr_r];
  assign count   = count_r;

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (count_r != '0))
    else $error("operand queue popped while empty");

endmodule

@@ rtl/dsst_back.sv @@
// Back end: Laplacian, gain multiply, rounding, saturation and the output register.
module dsst_back import dsst_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [GAIN_W-1:0]  gain,
  input  logic [Q_CNT_W-1:0] q_count,
  input  dsst_op_t           head_op,
  output logic               pop,
  dsst_out_if.source         out_stream
);

  logic                     en;
  logic [LAP_W-1:0]         lap;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] rounded;
  logic signed [DELTA_W-1:0] delta;
  logic signed [SUM_W-1:0]  sum;
  logic [CELL_W-1:0]        sat;
  logic [CELL_W-1:0]        result;

  logic                     b1_v_r;
  logic signed [LAP_W-1:0]  lap_r;
  logic [CELL_W-1:0]        old1_r;
  logic                     border1_r;
  logic                     last1_r;

  logic                     b2_v_r;
  logic signed [PROD_W-1:0] prod_r;
  logic [CELL_W-1:0]        old2_r;
  logic                     border2_r;
  logic                     last2_r;

  logic                     out_valid_r;
  logic [CELL_W-1:0]        new_value_r;
  logic                     last_r;

  assign en  = !out_valid_r || out_stream.ready;
  assign pop = en && (q_count != '0);

  // The true value fits in LAP_W signed bits, so modular arithmetic gives it exactly.
  assign lap = LAP_W'(head_op.up) + LAP_W'(head_op.below) + LAP_W'(head_op.left)
             + LAP_W'(head_op.right) - LAP_W'({head_op.old, 2'b00});

  assign prod = lap_r * $signed({1'b0, gain});

  assign rounded = prod_r + $signed(ROUND_HALF);
  assign delta   = rounded[PROD_W-1:FRAC_W];
  assign sum     = $signed({(SUM_W-CELL_W)'(0), old2_r})
                 + $signed({{(SUM_W-DELTA_W){delta[DELTA_W-1]}}, delta});

  always_comb begin
    if (sum[SUM_W-1]) begin
      sat = '0;
    end else if (|sum[SUM_W-2:CELL_W]) begin
      sat = '1;
    end else begin
      sat = sum[CELL_W-1:0];
    end
    result = border2_r ? old2_r : sat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r      <= 1'b0;
      b2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      b1_v_r      <= pop;
      b2_v_r      <= b1_v_r;
      out_valid_r <= b2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lap_r       <= $signed(lap);
      old1_r      <= head_op.old;
      border1_r   <= head_op.border;
      last1_r     <= head_op.last;
      prod_r      <= prod;
      old2_r      <= old1_r;
      border2_r   <= border1_r;
      last2_r     <= last1_r;
      new_value_r <= result;
      last_r      <= last2_r;
    end
  end

  assign out_stream.valid         = out_valid_r;
  assign out_stream.new_value     = new_value_r;
  assign out_stream.last_of_frame = last_r;

endmodule

@@ rtl/diffusion_stencil_step.sv @@
// Top level of the five-point explicit diffusion step over a streamed square grid.
// The grid enters in raster order, one cell per transfer, and the block accepts one
// transfer per clock cycle whenever its operand queue has room. Each result comes out
// of a six-stage path: two delay-line read stages, the queue, the Laplacian, the gain
// multiply and the output register. The result for cell p is offered once stream item
// p + n + 1 has passed through that path, where n is the clamped grid side. After the n*n
// cells of a frame, feed n + 1 flush transfers (kind = 1) to drain the remaining results;
// flushes sent earlier are taken and dropped, and extra cells past the end of the frame
// act as flushes. Interior cells get old + gain * (four neighbors - 4 * old), rounded to
// nearest with ties up and saturated to the unsigned Q2.30 range; cells on the border
// pass through unchanged, and last_of_frame marks the final cell of the grid. The row
// delay lines are two single-port-per-direction RAMs of MAX_GRID words that need no
// clearing pass: a cell is only ever combined with neighbors written earlier in the same
// frame. Write grid_size and diffusion_gain only while the block is idle; a grid_size
// write restarts the frame.
module diffusion_stencil_step import dsst_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  dsst_in_if.sink               in_stream,
  dsst_out_if.source            out_stream,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [GRID_W-1:0]  grid_size_r, grid_size_nxt;
  logic [GAIN_W-1:0]  gain_r, gain_nxt;
  logic [SIDE_W-1:0]  side;
  logic               restart;
  logic [Q_CNT_W-1:0] q_count;
  logic               push;
  logic               pop;
  dsst_op_t           push_op;
  dsst_op_t           head_op;

  // Configuration writes. A new grid size takes effect on the same edge that clears
  // the frame position, so the counters never see a stale side.
  assign restart = cfg_we && (cfg_index == REG_GRID_SIZE);

  always_comb begin
    grid_size_nxt = grid_size_r;
    gain_nxt      = gain_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_GRID_SIZE:      grid_size_nxt = cfg_wdata[GRID_W-1:0];
        REG_DIFFUSION_GAIN: gain_nxt      = cfg_wdata[GAIN_W-1:0];
        default:            grid_size_nxt = grid_size_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_size_r <= GRID_RESET;
      gain_r      <= GAIN_RESET;
    end else begin
      grid_size_r <= grid_size_nxt;
      gain_r      <= gain_nxt;
    end
  end

  assign side = dsst_side(grid_size_r);

  // The front end walks the raster, runs both row delay lines and emits one operand
  // record per result; it only stalls its input when the queue could overflow.
  dsst_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stream (in_stream),
    .side      (side),
    .restart   (restart),
    .q_count   (q_count),
    .push      (push),
    .push_op   (push_op)
  );

  // The queue lets the arithmetic stall on output back-pressure without freezing
  // the delay lines.
  dsst_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .head_op (head_op),
    .count   (q_count)
  );

  // The back end is a three-stage stallable pipeline ending in the output register.
  dsst_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .gain       (gain_r),
    .q_count    (q_count),
    .head_op    (head_op),
    .pop        (pop),
    .out_stream (out_stream)
  );

endmodule
